// ===== hdl/smcp_pkg.sv =====
// ----------------------------------------------------------------------------
// smcp_pkg: shared types and constants of the serial motor command parser
// Holds the command codes, the value field defaults and character classes.
// ----------------------------------------------------------------------------
`default_nettype none

package smcp_pkg;

	// Default width of the signed drive values.
	localparam int VALUE_BITS_DEF = 16;

	// Characters that the parser reacts to.
	localparam logic [7:0] CH_NEWLINE = 8'd10;
	localparam logic [7:0] CH_COMMA   = 8'd44;
	localparam logic [7:0] CH_PLUS    = 8'd43;
	localparam logic [7:0] CH_MINUS   = 8'd45;
	localparam logic [7:0] CH_ZERO    = 8'd48;
	localparam logic [7:0] CH_NINE    = 8'd57;

	// Command code of one result transaction.
	typedef enum logic [2:0] {
		OP_NOTHING = 3'd0,
		OP_DRIVE   = 3'd1,
		OP_CALIB   = 3'd2,
		OP_HALT    = 3'd3,
		OP_PS2     = 3'd4,
		OP_UART    = 3'd5
	} cmd_t;

	// Progress of one value field.
	typedef enum logic [1:0] {
		FP_SKIP = 2'd0,
		FP_RUN  = 2'd1,
		FP_DONE = 2'd2
	} field_phase_t;

	// Whitespace is space and the control characters tab through carriage return.
	function automatic logic is_ws(input logic [7:0] c);
		return (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= CH_ZERO) && (c <= CH_NINE);
	endfunction

endpackage

`default_nettype wire

// ===== hdl/smcp_field.sv =====
// ----------------------------------------------------------------------------
// smcp_field: one comma-separated value field
// Follows the field character by character: skips leading whitespace, takes
// an optional sign and decimal digits, and keeps a saturated magnitude.
// ----------------------------------------------------------------------------
`default_nettype none

module smcp_field #(
	parameter int VALUE_BITS = smcp_pkg::VALUE_BITS_DEF
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          clear,
	input  wire                          feed,
	input  wire  [7:0]                   char_in,
	output logic signed [VALUE_BITS-1:0] value
);
	import smcp_pkg::*;

	localparam int WB = VALUE_BITS + 4;

	field_phase_t            phase_q;
	logic                    negative_q;
	logic [VALUE_BITS-1:0]   mag_q;

	logic [3:0]              digit;
	logic [WB-1:0]           scaled;
	logic [WB-1:0]           cap;
	logic [VALUE_BITS-1:0]   mag_add;
	field_phase_t            phase_d;
	logic                    negative_d;
	logic [VALUE_BITS-1:0]   mag_d;

	// Magnitude times ten plus the new digit, capped at two to the VALUE_BITS-1.
	always_comb begin
		digit   = 4'(char_in - CH_ZERO);
		cap     = WB'(1) << (VALUE_BITS - 1);
		scaled  = {1'b0, mag_q, 3'b000} + {3'b000, mag_q, 1'b0} + {{VALUE_BITS{1'b0}}, digit};
		mag_add = (scaled > cap) ? cap[VALUE_BITS-1:0] : scaled[VALUE_BITS-1:0];
	end

	// Per-character update of the field.
	always_comb begin
		phase_d    = phase_q;
		negative_d = negative_q;
		mag_d      = mag_q;
		case (phase_q)
			FP_SKIP: begin
				if (!is_ws(char_in)) begin
					if (char_in == CH_PLUS) begin
						phase_d = FP_RUN;
					end else if (char_in == CH_MINUS) begin
						negative_d = 1'b1;
						phase_d    = FP_RUN;
					end else if (is_digit(char_in)) begin
						mag_d   = mag_add;
						phase_d = FP_RUN;
					end else begin
						phase_d = FP_DONE;
					end
				end
			end
			FP_RUN: begin
				if (is_digit(char_in)) begin
					mag_d = mag_add;
				end else begin
					phase_d = FP_DONE;
				end
			end
			default: begin
				phase_d = phase_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= FP_SKIP;
			negative_q <= 1'b0;
			mag_q      <= '0;
		end else if (clear) begin
			phase_q    <= FP_SKIP;
			negative_q <= 1'b0;
			mag_q      <= '0;
		end else if (feed) begin
			phase_q    <= phase_d;
			negative_q <= negative_d;
			mag_q      <= mag_d;
		end
	end

	// Signed value: a positive magnitude at the cap clips to the largest value.
	always_comb begin
		if (negative_q) begin
			value = -$signed(mag_q);
		end else if (mag_q[VALUE_BITS-1]) begin
			value = $signed({1'b0, {(VALUE_BITS-1){1'b1}}});
		end else begin
			value = $signed(mag_q);
		end
	end

endmodule

`default_nettype wire

// ===== hdl/serial_motor_command_parser.sv =====
// A newline waits in the character register and is then loaded into the result register.
// Throughput: one character per cycle; the character register and the result
//   register part the channels, so only a newline waits, while the result
//   register is still full and stalled.
// Reset: arst_n clears all line state, the character valid and the result
//   valid at once; no clearing pass follows.
// ----------------------------------------------------------------------------
// serial_motor_command_parser: line parser for serial motor commands
// Parses newline-ended command lines without a line buffer and gives one
// result transaction per line: a command code and two signed drive values.
// ----------------------------------------------------------------------------
`default_nettype none

module serial_motor_command_parser #(
	parameter int VALUE_BITS = smcp_pkg::VALUE_BITS_DEF
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          byte_valid,
	output logic                         byte_stall,
	input  wire  [7:0]                   in_byte,
	output logic                         result_valid,
	input  wire                          result_stall,
	output logic [2:0]                   command,
	output logic signed [VALUE_BITS-1:0] left_value,
	output logic signed [VALUE_BITS-1:0] right_value
);
	import smcp_pkg::*;

	// Keyword matcher states.
	typedef enum logic [3:0] {
		KW_START = 4'd0,
		KW_C     = 4'd1,
		KW_S     = 4'd2,
		KW_P     = 4'd3,
		KW_PS    = 4'd4,
		KW_PS2   = 4'd5,
		KW_SE    = 4'd6,
		KW_SER   = 4'd7,
		KW_DEAD  = 4'd15
	} kw_t;

	// Line prefix tracker for the "M," form.
	typedef enum logic [1:0] {
		PF_NONE   = 2'd0,
		PF_M      = 2'd1,
		PF_MCOMMA = 2'd2,
		PF_OTHER  = 2'd3
	} prefix_t;

	function automatic kw_t next_keyword(input kw_t s, input logic [7:0] c);
		kw_t n;
		n = KW_DEAD;
		case (s)
			KW_START: begin
				if (c == "C") n = KW_C;
				else if (c == "S") n = KW_S;
				else if (c == "P") n = KW_P;
			end
			KW_S:    if (c == "E") n = KW_SE;
			KW_P:    if (c == "S") n = KW_PS;
			KW_PS:   if (c == "2") n = KW_PS2;
			KW_SE:   if (c == "R") n = KW_SER;
			default: n = KW_DEAD;
		endcase
		return n;
	endfunction

	// Character register.
	logic       valid_s1;
	logic [7:0] char_s1;

	// Line state.
	logic       seen_q;
	kw_t        kw_q;
	logic       gap_q;
	prefix_t    prefix_q;
	logic [1:0] comma_q;

	// Result register.
	logic                         res_valid_q;
	cmd_t                         cmd_q;
	logic signed [VALUE_BITS-1:0] left_q;
	logic signed [VALUE_BITS-1:0] right_q;

	logic                         byte_accept;
	logic                         is_nl;
	logic                         go;
	logic                         out_load;
	logic                         take_comma;
	logic [2:0]                   feed;
	logic signed [VALUE_BITS-1:0] fval [3];
	cmd_t                         cmd_d;
	logic signed [VALUE_BITS-1:0] left_d;
	logic signed [VALUE_BITS-1:0] right_d;

	// Handshake: only a newline needs a free result register to move on.
	assign byte_accept = byte_valid && !byte_stall;
	assign is_nl       = (char_s1 == CH_NEWLINE);
	assign go          = valid_s1 && (!is_nl || !res_valid_q || !result_stall);
	assign byte_stall  = valid_s1 && !go;
	assign out_load    = go && is_nl;
	assign take_comma  = (char_s1 == CH_COMMA) && (comma_q < 2'd2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_accept) begin
			valid_s1 <= 1'b1;
		end else if (go) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_accept) begin
			char_s1 <= in_byte;
		end
	end

	// Each character but the newline and the first two commas goes to the field selected by the comma count.
	always_comb begin
		feed = '0;
		if (go && !is_nl && !take_comma) begin
			feed[comma_q] = 1'b1;
		end
	end

	for (genvar k = 0; k < 3; k++) begin : g_field
		smcp_field #(
			.VALUE_BITS(VALUE_BITS)
		) u_field (
			.clk     (clk),
			.arst_n  (arst_n),
			.clear   (out_load),
			.feed    (feed[k]),
			.char_in (char_s1),
			.value   (fval[k])
		);
	end

	// Keyword, prefix and comma tracking; everything clears at line end.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q   <= 1'b0;
			kw_q     <= KW_START;
			gap_q    <= 1'b0;
			prefix_q <= PF_NONE;
			comma_q  <= '0;
		end else if (out_load) begin
			seen_q   <= 1'b0;
			kw_q     <= KW_START;
			gap_q    <= 1'b0;
			prefix_q <= PF_NONE;
			comma_q  <= '0;
		end else if (go) begin
			if (is_ws(char_s1)) begin
				if (seen_q) begin
					gap_q <= 1'b1;
				end
				if (prefix_q == PF_M) begin
					prefix_q <= PF_OTHER;
				end
			end else begin
				if (gap_q) begin
					kw_q  <= KW_DEAD;
					gap_q <= 1'b0;
				end else begin
					kw_q <= next_keyword(kw_q, char_s1);
				end
				if (prefix_q == PF_NONE) begin
					prefix_q <= (char_s1 == "M") ? PF_M : PF_OTHER;
				end else if (prefix_q == PF_M) begin
					prefix_q <= (char_s1 == CH_COMMA) ? PF_MCOMMA : PF_OTHER;
				end
				seen_q <= 1'b1;
			end
			if (take_comma) begin
				comma_q <= comma_q + 2'd1;
			end
		end
	end

	// Line decode at the newline.
	always_comb begin
		cmd_d   = OP_NOTHING;
		left_d  = '0;
		right_d = '0;
		if (seen_q) begin
			if (kw_q == KW_C) begin
				cmd_d = OP_CALIB;
			end else if (kw_q == KW_S) begin
				cmd_d = OP_HALT;
			end else if (kw_q == KW_PS2) begin
				cmd_d = OP_PS2;
			end else if (kw_q == KW_SER) begin
				cmd_d = OP_UART;
			end else if (prefix_q == PF_MCOMMA) begin
				if (comma_q >= 2'd2) begin
					cmd_d   = OP_DRIVE;
					left_d  = fval[1];
					right_d = fval[2];
				end
			end else if (comma_q >= 2'd1) begin
				cmd_d   = OP_DRIVE;
				left_d  = fval[0];
				right_d = fval[1];
			end
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (out_load) begin
			res_valid_q <= 1'b1;
		end else if (!result_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			cmd_q   <= cmd_d;
			left_q  <= left_d;
			right_q <= right_d;
		end
	end

	assign result_valid = res_valid_q;
	assign command      = cmd_q;
	assign left_value   = left_q;
	assign right_value  = right_q;

endmodule

`default_nettype wire

// ===== hdl/smcp_checker.sv =====
// ----------------------------------------------------------------------------
// smcp_checker: port-level checks of the serial motor command parser
// Watches the character and result channels and is bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module smcp_checker #(
	parameter int VALUE_BITS = smcp_pkg::VALUE_BITS_DEF
) (
	input wire                          clk,
	input wire                          arst_n,
	input wire                          byte_valid,
	input wire                          byte_stall,
	input wire  [7:0]                   in_byte,
	input wire                          result_valid,
	input wire                          result_stall,
	input wire  [2:0]                   command,
	input wire  signed [VALUE_BITS-1:0] left_value,
	input wire  signed [VALUE_BITS-1:0] right_value
);
	import smcp_pkg::*;

	// A stalled result transaction stays offered.
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid)
		else $error("result transaction dropped while stalled");

	// A new result follows a newline via character and result registers.
	a_result_from_newline: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |->
		$past(byte_valid && !byte_stall && in_byte == CH_NEWLINE, 2))
		else $error("result without a preceding newline");

	// Command codes stay within the defined set.
	a_command_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> command <= OP_UART)
		else $error("undefined command code");

	// Only a motor command carries drive values.
	a_values_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && command != OP_DRIVE |-> left_value == '0 && right_value == '0)
		else $error("non-motor command with nonzero values");

endmodule

bind serial_motor_command_parser smcp_checker #(
	.VALUE_BITS(VALUE_BITS)
) u_smcp_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.byte_valid   (byte_valid),
	.byte_stall   (byte_stall),
	.in_byte      (in_byte),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.command      (command),
	.left_value   (left_value),
	.right_value  (right_value)
);

`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for serial_motor_command_parser
// Feeds command lines one character per transaction, first a table of
// directed lines and then random lines, mostly well formed. A line parser
// written here predicts results the table leaves open; all results
// are checked field by field. Both sides idle at random; the result
// side holds off long so that the parser fills up and stalls its input.
// ----------------------------------------------------------------------------

module testbench;
	import smcp_pkg::*;

	localparam int VBITS = VALUE_BITS_DEF;
	localparam int MAG_CAP = 1 << (VBITS - 1);
	localparam int RANDOM_CHARS = 700;

	// One parsed line as the parser reports it.
	typedef struct packed {
		cmd_t                    command;
		logic signed [VBITS-1:0] left;
		logic signed [VBITS-1:0] right;
	} line_result_t;

	// Per line: either a result typed in by hand or one left to the line parser.
	typedef struct packed {
		bit                      known;
		cmd_t                    command;
		logic signed [VBITS-1:0] left;
		logic signed [VBITS-1:0] right;
	} line_hint_t;

	localparam line_hint_t DERIVED = '{1'b0, OP_NOTHING, 0, 0};

	// Keyword matcher states of the line parser.
	typedef enum logic [3:0] {
		MATCH_IDLE = 4'd0,
		MATCH_C    = 4'd1,
		MATCH_S    = 4'd2,
		MATCH_P    = 4'd3,
		MATCH_PS   = 4'd4,
		MATCH_PS2  = 4'd5,
		MATCH_SE   = 4'd6,
		MATCH_SER  = 4'd7,
		MATCH_NONE = 4'd15
	} match_t;

	// What the start of the line looks like.
	typedef enum logic [1:0] {
		LEAD_EMPTY,
		LEAD_M,
		LEAD_M_COMMA,
		LEAD_OTHER
	} lead_t;

	// Directed lines; the newline is appended when the line is queued.
	localparam int DIR_ROWS = 21;
	localparam int NUL_ROW = 16;
	string dir_text [DIR_ROWS] = '{
		"",
		" \t\013\014\r ",
		"C",
		"  S\t",
		"PS2",
		" SER ",
		"P S2",
		"SERX",
		"hello",
		"M,32767,-32768",
		"M,99999,-99999",
		"-32769,32768",
		"M,5",
		"M,,",
		"1,2,3,4",
		"M, +12 , -7x9",
		"5,7",
		"\377\200,3",
		"m,1,2",
		" M,-0,+",
		"M ,4,5"
	};
	line_hint_t dir_hint [DIR_ROWS] = '{
		'{1'b1, OP_NOTHING, 0, 0},
		'{1'b1, OP_NOTHING, 0, 0},
		'{1'b1, OP_CALIB, 0, 0},
		'{1'b1, OP_HALT, 0, 0},
		'{1'b1, OP_PS2, 0, 0},
		'{1'b1, OP_UART, 0, 0},
		'{1'b1, OP_NOTHING, 0, 0},
		'{1'b1, OP_NOTHING, 0, 0},
		'{1'b1, OP_NOTHING, 0, 0},
		'{1'b1, OP_DRIVE, 32767, -32768},
		'{1'b1, OP_DRIVE, 32767, -32768},
		'{1'b1, OP_DRIVE, -32768, 32767},
		'{1'b1, OP_NOTHING, 0, 0},
		'{1'b1, OP_DRIVE, 0, 0},
		DERIVED,
		DERIVED,
		DERIVED,
		DERIVED,
		DERIVED,
		DERIVED,
		DERIVED
	};

	logic                    clk = 1'b0;
	logic                    arst_n;
	logic                    byte_valid;
	logic                    byte_stall;
	logic [7:0]              in_byte;
	logic                    result_valid;
	logic                    result_stall;
	logic [2:0]              command;
	logic signed [VBITS-1:0] left_value;
	logic signed [VBITS-1:0] right_value;

	// Pacing flags for the two sides: one calm flag each, and the result hold-off.
	logic tx_calm;
	logic rx_calm;
	logic choke;

	logic [7:0]   tx_chars [$];
	line_hint_t   line_hints [$];
	line_result_t pending_results [$];

	int accepted_chars = 0;
	int blocked_cycles = 0;
	int mismatches = 0;
	int motor_results = 0;
	int keyword_results = 0;
	int quiet_results = 0;

	// Line parser state.
	logic                 line_busy;
	match_t               kw;
	logic                 spaced;
	lead_t                lead;
	logic [1:0]           n_commas;
	field_phase_t         fld_phase [3];
	logic                 fld_neg [3];
	logic [VBITS-1:0]     fld_mag [3];

	serial_motor_command_parser #(
		.VALUE_BITS(VBITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.byte_valid(byte_valid),
		.byte_stall(byte_stall),
		.in_byte(in_byte),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.command(command),
		.left_value(left_value),
		.right_value(right_value)
	);

	always #5 clk = ~clk;

	// ------------------------------------------------------------------
	// Line parser used for prediction
	// ------------------------------------------------------------------

	function automatic logic blank_char(logic [7:0] c);
		return (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
	endfunction

	function automatic logic dec_digit(logic [7:0] c);
		return (c >= CH_ZERO) && (c <= CH_NINE);
	endfunction

	function automatic void forget_line();
		line_busy = 1'b0;
		kw = MATCH_IDLE;
		spaced = 1'b0;
		lead = LEAD_EMPTY;
		n_commas = 2'd0;
		for (int k = 0; k < 3; k++) begin
			fld_phase[k] = FP_SKIP;
			fld_neg[k] = 1'b0;
			fld_mag[k] = '0;
		end
	endfunction

	// Decimal accumulation saturates just past the largest positive value.
	function automatic void absorb_digit(int k, logic [7:0] c);
		int m;
		m = int'(fld_mag[k]) * 10 + int'(c - CH_ZERO);
		if (m > MAG_CAP)
			m = MAG_CAP;
		fld_mag[k] = m[VBITS-1:0];
	endfunction

	// Integer conversion of one field: blanks, sign, digits, then stop.
	function automatic void field_take(int k, logic [7:0] c);
		if (fld_phase[k] == FP_SKIP) begin
			if (!blank_char(c)) begin
				if (c == CH_PLUS) begin
					fld_phase[k] = FP_RUN;
				end else if (c == CH_MINUS) begin
					fld_neg[k] = 1'b1;
					fld_phase[k] = FP_RUN;
				end else if (dec_digit(c)) begin
					absorb_digit(k, c);
					fld_phase[k] = FP_RUN;
				end else begin
					fld_phase[k] = FP_DONE;
				end
			end
		end else if (fld_phase[k] == FP_RUN) begin
			if (dec_digit(c))
				absorb_digit(k, c);
			else
				fld_phase[k] = FP_DONE;
		end
	endfunction

	function automatic logic signed [VBITS-1:0] fld_value(int k);
		int m;
		m = int'(fld_mag[k]);
		if (fld_neg[k])
			m = -m;
		else if (m >= MAG_CAP)
			m = MAG_CAP - 1;
		return m[VBITS-1:0];
	endfunction

	function automatic match_t next_match(match_t s, logic [7:0] c);
		case (s)
			MATCH_IDLE: begin
				if (c == "C") return MATCH_C;
				if (c == "S") return MATCH_S;
				if (c == "P") return MATCH_P;
				return MATCH_NONE;
			end
			MATCH_S:  return (c == "E") ? MATCH_SE : MATCH_NONE;
			MATCH_P:  return (c == "S") ? MATCH_PS : MATCH_NONE;
			MATCH_PS: return (c == "2") ? MATCH_PS2 : MATCH_NONE;
			MATCH_SE: return (c == "R") ? MATCH_SER : MATCH_NONE;
			default:  return MATCH_NONE;
		endcase
	endfunction

	// Takes one character; returns 1 with the line's result on a newline.
	function automatic bit parse_char(logic [7:0] c, output line_result_t r);
		r = '{OP_NOTHING, 0, 0};
		if (c != CH_NEWLINE) begin
			if (blank_char(c)) begin
				if (line_busy)
					spaced = 1'b1;
				if (lead == LEAD_M)
					lead = LEAD_OTHER;
			end else begin
				if (spaced) begin
					kw = MATCH_NONE;
					spaced = 1'b0;
				end else begin
					kw = next_match(kw, c);
				end
				if (lead == LEAD_EMPTY)
					lead = (c == "M") ? LEAD_M : LEAD_OTHER;
				else if (lead == LEAD_M)
					lead = (c == CH_COMMA) ? LEAD_M_COMMA : LEAD_OTHER;
				line_busy = 1'b1;
			end
			if (c == CH_COMMA && n_commas < 2'd2)
				n_commas++;
			else
				field_take(n_commas, c);
			return 1'b0;
		end

		if (line_busy) begin
			case (kw)
				MATCH_C:   r.command = OP_CALIB;
				MATCH_S:   r.command = OP_HALT;
				MATCH_PS2: r.command = OP_PS2;
				MATCH_SER: r.command = OP_UART;
				default: begin
					if (lead == LEAD_M_COMMA) begin
						if (n_commas >= 2'd2)
							r = '{OP_DRIVE, fld_value(1), fld_value(2)};
					end else if (n_commas >= 2'd1) begin
						r = '{OP_DRIVE, fld_value(0), fld_value(1)};
					end
				end
			endcase
		end
		forget_line();
		return 1'b1;
	endfunction

	// ------------------------------------------------------------------
	// Stimulus construction
	// ------------------------------------------------------------------

	function automatic int idle_len(logic calm);
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 55)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 45);
	endfunction

	function automatic void put_text(string s);
		for (int i = 0; i < s.len(); i++)
			tx_chars.push_back(s[i]);
	endfunction

	function automatic void put_blank(int most);
		int n;
		int r;
		n = $urandom_range(0, most);
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(0, 7);
			tx_chars.push_back(r < 4 ? 8'd32 : (r == 4 ? 8'd9 : 8'(r + 6)));
		end
	endfunction

	// A value as it might be typed: sometimes empty, padded, signed or overlong.
	function automatic string num_text();
		string s;
		int v;
		int pick;
		int sign;
		pick = $urandom_range(0, 19);
		if (pick == 0)
			return "";
		if (pick < 8)
			v = $urandom_range(0, 99);
		else if (pick < 14)
			v = $urandom_range(0, 32767);
		else if (pick < 17)
			v = $urandom_range(32760, 32780);
		else
			v = $urandom_range(0, 99999999);
		s = $sformatf("%0d", v);
		if ($urandom_range(0, 5) == 0)
			s = {"00", s};
		sign = $urandom_range(0, 3);
		if (sign == 1)
			s = {"+", s};
		else if (sign >= 2)
			s = {"-", s};
		if ($urandom_range(0, 4) == 0)
			s = {" ", s};
		if ($urandom_range(0, 7) == 0)
			s = {s, "x"};
		return s;
	endfunction

	// One random line: mostly valid commands with random values, some broken
	// lines, noise and blank lines.
	function automatic void add_random_line();
		int kind;
		int n;
		string kwd;
		logic [7:0] b;
		kind = $urandom_range(0, 99);
		case ($urandom_range(0, 3))
			0:       kwd = "C";
			1:       kwd = "S";
			2:       kwd = "PS2";
			default: kwd = "SER";
		endcase
		if (kind < 15) begin
			put_blank(2);
			put_text(kwd);
			put_blank(2);
		end else if (kind < 45) begin
			put_blank(1);
			put_text({"M,", num_text(), ",", num_text()});
			if ($urandom_range(0, 4) == 0)
				put_text({",", num_text()});
			put_blank(2);
		end else if (kind < 63) begin
			put_blank(1);
			put_text({num_text(), ",", num_text()});
			put_blank(2);
		end else if (kind < 73) begin
			n = $urandom_range(0, 2);
			if (n == 0) begin
				put_text(kwd.substr(0, 0));
				put_text(" ");
				put_text(kwd.len() > 1 ? kwd.substr(1, kwd.len() - 1) : kwd);
			end else if (n == 1) begin
				put_text({kwd, "Q"});
			end else begin
				put_text(kwd.tolower());
			end
		end else if (kind < 83) begin
			n = $urandom_range(0, 3);
			if (n == 0)
				put_text({"M,", num_text()});
			else if (n == 1)
				put_text({"M ,", num_text(), ",", num_text()});
			else if (n == 2)
				put_text("M");
			else
				put_text({"M", num_text(), ",", num_text()});
		end else if (kind < 94) begin
			n = $urandom_range(1, 12);
			for (int i = 0; i < n; i++) begin
				b = 8'($urandom_range(0, 254));
				if (b >= CH_NEWLINE)
					b++;
				tx_chars.push_back(b);
			end
		end else begin
			put_blank(3);
		end
		tx_chars.push_back(CH_NEWLINE);
		line_hints.push_back(DERIVED);
	endfunction

	// ------------------------------------------------------------------
	// Reset, character feed and end of run
	// ------------------------------------------------------------------

	initial begin : feed
		int gap;
		int sent;
		arst_n <= 1'b0;
		byte_valid <= 1'b0;
		in_byte <= 8'd0;
		forget_line();

		// Directed lines from the table.
		for (int i = 0; i < DIR_ROWS; i++) begin
			if (i == NUL_ROW)
				tx_chars.push_back(8'd0);
			put_text(dir_text[i]);
			tx_chars.push_back(CH_NEWLINE);
			line_hints.push_back(dir_hint[i]);
		end
		gap = tx_chars.size() + RANDOM_CHARS;
		while (tx_chars.size() < gap)
			add_random_line();

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		sent = 0;
		while (sent < tx_chars.size()) begin
			gap = idle_len(tx_calm);
			if (gap > 0) begin
				byte_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			byte_valid <= 1'b1;
			in_byte <= tx_chars[sent];
			@(posedge clk);
			while (byte_stall)
				@(posedge clk);
			sent++;
		end
		byte_valid <= 1'b0;
		@(posedge clk);

		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);

		$display("Sent %0d characters; results: %0d motor, %0d keyword,",
			accepted_chars, motor_results, keyword_results);
		$display("%0d empty or rejected; input was refused for %0d cycles while held back.",
			quiet_results, blocked_cycles);
		if (mismatches == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	// Idle and busy stretches for both sides.
	initial begin : pace
		tx_calm <= 1'b0;
		rx_calm <= 1'b0;
		forever begin
			repeat (200) @(posedge clk);
			tx_calm <= ($urandom_range(0, 3) == 0);
			rx_calm <= ($urandom_range(0, 3) == 0);
		end
	end

	// Long result hold-offs so the parser fills up and refuses characters.
	initial begin : hold_off
		choke <= 1'b0;
		repeat (400) @(posedge clk);
		choke <= 1'b1;
		repeat (120) @(posedge clk);
		choke <= 1'b0;
		repeat (2500) @(posedge clk);
		choke <= 1'b1;
		repeat (120) @(posedge clk);
		choke <= 1'b0;
	end

	// Result side stall, in random bursts.
	initial begin : drain
		int burst;
		burst = 0;
		result_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (choke) begin
				result_stall <= 1'b1;
			end else if (burst > 0) begin
				burst--;
				result_stall <= 1'b1;
			end else begin
				burst = idle_len(rx_calm);
				result_stall <= (burst > 0);
				if (burst > 0)
					burst--;
			end
		end
	end

	// ------------------------------------------------------------------
	// Monitors
	// ------------------------------------------------------------------

	// Every accepted character advances the line parser; a newline queues
	// the expected result, typed in or predicted.
	always @(posedge clk) begin : watch_chars
		line_result_t guess;
		line_hint_t hint;
		if (arst_n && byte_valid && byte_stall)
			blocked_cycles++;
		if (arst_n && byte_valid && !byte_stall) begin
			accepted_chars++;
			if (parse_char(in_byte, guess)) begin
				hint = line_hints.pop_front();
				if (hint.known)
					guess = '{hint.command, hint.left, hint.right};
				pending_results.push_back(guess);
			end
		end
	end

	// Each result transaction is compared with the oldest expectation.
	always @(posedge clk) begin : check_results
		line_result_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (pending_results.size() == 0) begin
				if (mismatches < 10)
					$display("Unexpected result: cmd %0d left %0d right %0d",
						command, left_value, right_value);
				mismatches++;
			end else begin
				want = pending_results.pop_front();
				if (want.command == OP_DRIVE)
					motor_results++;
				else if (want.command == OP_NOTHING)
					quiet_results++;
				else
					keyword_results++;
				if (command !== want.command || left_value !== want.left ||
					right_value !== want.right) begin
					if (mismatches < 10)
						$display({"Mismatch: expected cmd %0d left %0d right %0d,",
							" got cmd %0d left %0d right %0d"},
							want.command, want.left, want.right,
							command, left_value, right_value);
					mismatches++;
				end
			end
		end
	end

	// Ends a run that hangs.
	initial begin : watchdog
		#5_000_000;
		$display("Timeout with %0d results outstanding", pending_results.size());
		$display("Verification failed");
		$finish;
	end

endmodule
